### sv/qap_cost_evaluator_core_defines.svh
// Assertion helpers used by the cost evaluator core
`ifndef QAP_COST_EVALUATOR_CORE_DEFINES_SVH
`define QAP_COST_EVALUATOR_CORE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent
`define QAP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent
`define QAP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/qap_pkg.sv
`timescale 1ns / 1ps

package qap_pkg;

   // Fixed field widths
   localparam int COST_W  = 42;
   localparam int COUNT_W = 6;
   localparam int LOC_W   = 6;

   // Transaction kind carried in req_tuser
   localparam logic [1:0] FUNC_FLOW = 2'd0;
   localparam logic [1:0] FUNC_DIST = 2'd1;
   localparam logic [1:0] FUNC_PERM = 2'd2;

   // Result status carried in rsp_tuser
   localparam logic [1:0] STATUS_COMPLETE = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_BAD      = 2'd2;

   // Register index, taken from paddr bit 2
   localparam logic REG_NODE_COUNT      = 1'b0;
   localparam logic REG_MISSING_PENALTY = 1'b1;

   // Register reset values
   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 6'd32;
   localparam logic [31:0]        PENALTY_RESET    = 32'd0;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,
      S_PI,
      S_COL,
      S_DRAIN,
      S_EMIT
   } state_type;

endpackage

### sv/qap_ram.sv
`timescale 1ns / 1ps

module qap_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/qap_cost_evaluator_core.sv
`timescale 1ns / 1ps
// Quadratic assignment cost evaluator.
// req channel: tuser selects the transaction kind (flow write, distance
// write, permutation entry); tdata carries row, col, value and location;
// tlast marks the final permutation entry. Matrix writes and non-final
// permutation entries give no result.
// The final permutation entry yields one rsp transaction: tdata holds the
// cost, tuser the status (complete, short permutation, bad entry).
// A short or bad permutation goes straight to the emit state. A complete
// one walks n*n flow/distance products through one shared
// multiply-accumulate pipeline: each row starts with one read of the row's
// location, then gives one product per cycle from the single read port of
// each store, and the pipeline drains after the last row; req_tready is
// low meanwhile.
// The result waits in an output register; while that register is still
// full and rsp_tready is low, the block holds in its emit state with
// req_tready low, so no further writes or evaluations are taken.
// Reset (synchronous) clears counters, status and sequencer and loads the
// register reset values; the stores hold their contents undefined until
// written. csr is an APB port: node_count at 0x0, missing_penalty at 0x4.

`include "qap_cost_evaluator_core_defines.svh"

module qap_cost_evaluator_core #(
   parameter int MAX_NODES   = 32,
   parameter int ENTRY_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] row, [9:5] col, [25:10] matrix_value, [31:26] location
   input  logic [31:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   input  logic        req_tlast,
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [41:0] cost, [47:42] zero
   output logic [47:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]  rsp_tuser,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES);
   localparam int LOOP_W = (IDX_W > 6) ? IDX_W : 6;
   localparam int PROD_W = 2 * ENTRY_WIDTH;
   localparam int COST_W = qap_pkg::COST_W;
   localparam int CNT_W  = qap_pkg::COUNT_W;

   // configuration registers
   logic [CNT_W-1:0] node_count_ff, node_count_in;
   logic [31:0]      penalty_ff, penalty_in;

   // sequencer and run state
   qap_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  perm_count_ff, perm_count_in;
   logic              bad_ff, bad_in;
   logic [IDX_W-1:0]  max_loc_ff, max_loc_in;
   logic [LOOP_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic [ADDR_W-1:0] pi_base_ff, pi_base_in;

   // multiply-accumulate pipeline
   logic [2:0]        pipe_v_ff, pipe_v_in;
   logic [ADDR_W-1:0] s1_flow_addr_ff, s1_flow_addr_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [COST_W-1:0] acc_ff, acc_in;
   logic [1:0]        status_ff, status_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // request fields
   logic [1:0]  req_func;
   logic [4:0]  req_row, req_col;
   logic [15:0] req_value;
   logic [5:0]  req_loc;

   assign req_func  = req_tuser;
   assign req_row   = req_tdata[4:0];
   assign req_col   = req_tdata[9:5];
   assign req_value = req_tdata[25:10];
   assign req_loc   = req_tdata[31:26];

   // effective node count
   logic [CNT_W-1:0]  eff_n;
   logic [LOOP_W-1:0] n_ext, n_last;

   always_comb begin
      if (node_count_ff == '0) begin
         eff_n = CNT_W'(1);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         eff_n = CNT_W'(MAX_NODES);
      end else begin
         eff_n = node_count_ff;
      end
   end

   assign n_ext  = LOOP_W'(eff_n);
   assign n_last = n_ext - LOOP_W'(1);

   // transaction decode
   logic req_accept, perm_item, eval_start, mat_in_range;
   logic flow_we, dist_we;
   logic [ADDR_W-1:0] mat_waddr;

   assign req_accept   = req_tvalid & req_tready;
   assign perm_item    = req_accept && (req_func == qap_pkg::FUNC_PERM);
   assign eval_start   = perm_item && req_tlast;
   assign mat_in_range = (32'(req_row) < MAX_NODES) && (32'(req_col) < MAX_NODES);
   assign flow_we      = req_accept && (req_func == qap_pkg::FUNC_FLOW) && mat_in_range;
   assign dist_we      = req_accept && (req_func == qap_pkg::FUNC_DIST) && mat_in_range;
   assign mat_waddr    = ADDR_W'(req_row) * ADDR_W'(MAX_NODES) + ADDR_W'(req_col);

   // permutation entry bookkeeping
   logic [LOOP_W-1:0] cnt_ext, loc_ext, max_new_ext;
   logic              perm_store_en, bad_new, eval_bad, eval_full;
   logic [CNT_W-1:0]  cnt_new;
   logic [IDX_W-1:0]  max_new;
   logic [COST_W-1:0] short_cost;

   assign cnt_ext       = LOOP_W'(perm_count_ff);
   assign loc_ext       = LOOP_W'(req_loc);
   assign perm_store_en = perm_item && (perm_count_ff < eff_n) && (req_loc < eff_n);
   assign bad_new       = bad_ff || !perm_store_en;
   assign cnt_new       = (perm_count_ff == '1) ? perm_count_ff : perm_count_ff + CNT_W'(1);
   assign max_new       = (perm_store_en && (loc_ext[IDX_W-1:0] > max_loc_ff)) ?
                          loc_ext[IDX_W-1:0] : max_loc_ff;
   assign max_new_ext   = LOOP_W'(max_new);
   assign eval_bad      = bad_new || (cnt_new > eff_n) ||
                          ((cnt_new == eff_n) && (max_new_ext >= n_ext));
   assign eval_full     = !eval_bad && (cnt_new == eff_n);
   assign short_cost    = COST_W'(eff_n - cnt_new) * COST_W'(penalty_ff);

   // stores
   logic [IDX_W-1:0]       perm_raddr, perm_rd;
   logic [ADDR_W-1:0]      dist_raddr;
   logic [ENTRY_WIDTH-1:0] flow_rd, dist_rd, mat_wdata;

   assign mat_wdata  = ENTRY_WIDTH'(req_value);
   assign dist_raddr = pi_base_ff + ADDR_W'(perm_rd);

   qap_ram #(.DEPTH(MAX_NODES * MAX_NODES), .DATA_W(ENTRY_WIDTH)) u_flow_ram (
      .clock   (clock),
      .wr_en   (flow_we),
      .wr_addr (mat_waddr),
      .wr_data (mat_wdata),
      .rd_addr (s1_flow_addr_ff),
      .rd_data (flow_rd)
   );

   qap_ram #(.DEPTH(MAX_NODES * MAX_NODES), .DATA_W(ENTRY_WIDTH)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (mat_waddr),
      .wr_data (mat_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_rd)
   );

   qap_ram #(.DEPTH(MAX_NODES), .DATA_W(IDX_W)) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_store_en),
      .wr_addr (cnt_ext[IDX_W-1:0]),
      .wr_data (loc_ext[IDX_W-1:0]),
      .rd_addr (perm_raddr),
      .rd_data (perm_rd)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qap_pkg::S_IDLE: begin
            if (eval_start) begin
               state_in = eval_full ? qap_pkg::S_ROW : qap_pkg::S_EMIT;
            end
         end
         qap_pkg::S_ROW: begin
            state_in = qap_pkg::S_PI;
         end
         qap_pkg::S_PI: begin
            state_in = qap_pkg::S_COL;
         end
         qap_pkg::S_COL: begin
            if (j_ff == n_last) begin
               state_in = (i_ff == n_last) ? qap_pkg::S_DRAIN : qap_pkg::S_ROW;
            end
         end
         qap_pkg::S_DRAIN: begin
            if (pipe_v_ff == '0) begin
               state_in = qap_pkg::S_EMIT;
            end
         end
         qap_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = qap_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = qap_pkg::S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      perm_raddr = j_ff[IDX_W-1:0];
      case (state_ff)
         qap_pkg::S_IDLE: begin
            req_tready = 1'b1;
         end
         qap_pkg::S_ROW: begin
            perm_raddr = i_ff[IDX_W-1:0];
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // configuration writes and reads
   logic csr_write;

   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      node_count_in = node_count_ff;
      penalty_in    = penalty_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            qap_pkg::REG_NODE_COUNT:      node_count_in = csr_pwdata[CNT_W-1:0];
            qap_pkg::REG_MISSING_PENALTY: penalty_in    = csr_pwdata;
            default:                      penalty_in    = penalty_ff;
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[2] == qap_pkg::REG_MISSING_PENALTY) ?
                       penalty_ff : 32'(node_count_ff);

   // datapath next values
   always_comb begin
      perm_count_in   = perm_count_ff;
      bad_in          = bad_ff;
      max_loc_in      = max_loc_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      row_base_in     = row_base_ff;
      pi_base_in      = pi_base_ff;
      acc_in          = acc_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_cost_in     = rsp_cost_ff;
      rsp_status_in   = rsp_status_ff;

      // shared multiply-accumulate pipeline
      pipe_v_in       = {pipe_v_ff[1], pipe_v_ff[0], state_ff == qap_pkg::S_COL};
      s1_flow_addr_in = row_base_ff + ADDR_W'(j_ff);
      prod_in         = PROD_W'(flow_rd) * PROD_W'(dist_rd);
      if (pipe_v_ff[2]) begin
         acc_in = acc_ff + COST_W'(prod_ff);
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         qap_pkg::S_IDLE: begin
            if (perm_item) begin
               perm_count_in = cnt_new;
               bad_in        = bad_new;
               max_loc_in    = max_new;
            end
            if (eval_start) begin
               perm_count_in = '0;
               bad_in        = 1'b0;
               max_loc_in    = '0;
               i_in          = '0;
               j_in          = '0;
               row_base_in   = '0;
               if (eval_bad) begin
                  acc_in    = '0;
                  status_in = qap_pkg::STATUS_BAD;
               end else if (eval_full) begin
                  acc_in    = '0;
                  status_in = qap_pkg::STATUS_COMPLETE;
               end else begin
                  acc_in    = short_cost;
                  status_in = qap_pkg::STATUS_SHORT;
               end
            end
         end
         qap_pkg::S_PI: begin
            pi_base_in = ADDR_W'(perm_rd) * ADDR_W'(MAX_NODES);
         end
         qap_pkg::S_COL: begin
            if (j_ff == n_last) begin
               j_in        = '0;
               i_in        = i_ff + LOOP_W'(1);
               row_base_in = row_base_ff + ADDR_W'(MAX_NODES);
            end else begin
               j_in = j_ff + LOOP_W'(1);
            end
         end
         qap_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_cost_in   = acc_ff;
               rsp_status_in = status_ff;
            end
         end
         default: begin
            acc_in = acc_in;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= qap_pkg::S_IDLE;
         node_count_ff <= qap_pkg::NODE_COUNT_RESET;
         penalty_ff    <= qap_pkg::PENALTY_RESET;
         perm_count_ff <= '0;
         bad_ff        <= 1'b0;
         max_loc_ff    <= '0;
         acc_ff        <= '0;
         status_ff     <= qap_pkg::STATUS_COMPLETE;
         pipe_v_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         penalty_ff    <= penalty_in;
         perm_count_ff <= perm_count_in;
         bad_ff        <= bad_in;
         max_loc_ff    <= max_loc_in;
         acc_ff        <= acc_in;
         status_ff     <= status_in;
         pipe_v_ff     <= pipe_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff            <= i_in;
      j_ff            <= j_in;
      row_base_ff     <= row_base_in;
      pi_base_ff      <= pi_base_in;
      s1_flow_addr_ff <= s1_flow_addr_in;
      prod_ff         <= prod_in;
      rsp_cost_ff     <= rsp_cost_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 48'(rsp_cost_ff);
   assign rsp_tuser  = rsp_status_ff;

   // checks
   `QAP_ASSERT_SAME(a_pipe_in_eval, clock, reset, pipe_v_ff != 3'b000, (state_ff == qap_pkg::S_ROW) || (state_ff == qap_pkg::S_PI) || (state_ff == qap_pkg::S_COL) || (state_ff == qap_pkg::S_DRAIN), "MAC pipeline busy outside evaluation")
   `QAP_ASSERT_SAME(a_emit_drained, clock, reset, state_ff == qap_pkg::S_EMIT, pipe_v_ff == 3'b000, "result emitted before pipeline drained")
   `QAP_ASSERT_NEXT(a_run_cleared, clock, reset, eval_start, (perm_count_ff == '0) && !bad_ff, "permutation run not cleared after evaluation")
   `QAP_ASSERT_SAME(a_bad_zero_cost, clock, reset, rsp_valid_ff && (rsp_status_ff == qap_pkg::STATUS_BAD), rsp_cost_ff == '0, "bad entry result with non-zero cost")

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import qap_pkg::*;

   localparam int          NODES_MAX    = 32;
   localparam int          RANDOM_ITEMS = 1250;
   localparam int          SETTLE       = 8;
   localparam int          TAIL_CYCLES  = 60;
   localparam int          LONG_HOLD    = 300;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   // func code the block has no use for
   localparam logic [1:0]  FUNC_NONE    = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [4:0]  row;
      logic [4:0]  col;
      logic [15:0] value;
      logic [5:0]  location;
      logic        last;
   } req_item_t;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [1:0]        status;
   } cost_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Stimulus and expectation queues
   req_item_t    req_pending_q[$];
   cost_result_t cost_expected_q[$];

   // Predicted block state
   logic [15:0] flow_mem [0:NODES_MAX*NODES_MAX-1];
   logic [15:0] dist_mem [0:NODES_MAX*NODES_MAX-1];
   logic [4:0]  perm_loc [0:NODES_MAX-1];
   logic [5:0]  perm_cnt = '0;
   bit          perm_bad = 1'b0;
   logic [5:0]  cfg_nodes = NODE_COUNT_RESET;
   logic [31:0] cfg_penalty = PENALTY_RESET;

   // Generator view: which store entries hold data, open permutation
   bit flow_set [0:NODES_MAX*NODES_MAX-1];
   bit dist_set [0:NODES_MAX*NODES_MAX-1];
   int gen_locs[$];
   int gen_count = 0;
   bit filling = 1'b0;

   // Flow control knobs
   int req_gap_pct = 0;
   int rsp_gap_pct = 0;
   bit quiet_tail = 1'b0;
   bit long_hold_req = 1'b0;
   bit long_hold_done = 1'b0;
   int hold_left = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   logic req_taken = 1'b0;

   int          fault_count = 0;
   int unsigned cycle_count = 0;

   qap_cost_evaluator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int eff_nodes(input logic [5:0] v);
      if (v == 6'd0) return 1;
      if (int'(v) > NODES_MAX) return NODES_MAX;
      return int'(v);
   endfunction

   function automatic void note_fault(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t mismatch in %s: expected %h, got %h", $realtime, what, want, got);
      end
   endfunction

   // Applies one accepted transaction to the predicted state; a final
   // permutation entry yields the expected cost and status
   function automatic void cost_step(input logic [1:0] func, input logic [31:0] data,
                                     input logic last);
      logic [4:0]   row;
      logic [4:0]   col;
      logic [15:0]  value;
      logic [5:0]   loc;
      int           n;
      bit           bad;
      logic [63:0]  acc;
      cost_result_t res;
      row   = data[4:0];
      col   = data[9:5];
      value = data[25:10];
      loc   = data[31:26];
      if (func == FUNC_FLOW) begin
         flow_mem[{row, col}] = value;
      end else if (func == FUNC_DIST) begin
         dist_mem[{row, col}] = value;
      end else if (func == FUNC_PERM) begin
         n = eff_nodes(cfg_nodes);
         if (int'(perm_cnt) >= n || int'(loc) >= n) begin
            perm_bad = 1'b1;
         end else begin
            perm_loc[perm_cnt] = loc[4:0];
         end
         if (perm_cnt < 6'd63) perm_cnt = perm_cnt + 6'd1;
         if (last) begin
            bad = perm_bad || int'(perm_cnt) > n;
            // stored locations are checked against the node count in force now
            if (!bad && int'(perm_cnt) == n) begin
               for (int i = 0; i < n; i++) begin
                  if (int'(perm_loc[i]) >= n) bad = 1'b1;
               end
            end
            acc = '0;
            if (bad) begin
               res.cost   = '0;
               res.status = STATUS_BAD;
            end else if (int'(perm_cnt) < n) begin
               acc        = 64'(n - int'(perm_cnt)) * 64'(cfg_penalty);
               res.cost   = acc[COST_W-1:0];
               res.status = STATUS_SHORT;
            end else begin
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < n; j++) begin
                     acc = acc + 64'(flow_mem[i*NODES_MAX+j]) *
                                 64'(dist_mem[{perm_loc[i], perm_loc[j]}]);
                  end
               end
               res.cost   = acc[COST_W-1:0];
               res.status = STATUS_COMPLETE;
            end
            cost_expected_q.push_back(res);
            perm_cnt = '0;
            perm_bad = 1'b0;
         end
      end
   endfunction

   function automatic int rand_value();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 65535;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic int pick_gap();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 5;
         2: return 20;
         default: return 50;
      endcase
   endfunction

   task automatic push_req(input logic [1:0] func, input int row, input int col,
                           input int value, input int loc, input bit last);
      req_item_t item;
      item.func     = func;
      item.row      = row[4:0];
      item.col      = col[4:0];
      item.value    = value[15:0];
      item.location = loc[5:0];
      item.last     = last;
      req_pending_q.push_back(item);
      if (func == FUNC_FLOW) flow_set[row*NODES_MAX+col] = 1'b1;
      if (func == FUNC_DIST) dist_set[row*NODES_MAX+col] = 1'b1;
      if (func != FUNC_NONE && !filling) gen_count++;
   endtask

   // Matrix write; location and tlast carry random don't-care values
   task automatic push_matrix(input logic [1:0] func, input int row, input int col,
                              input int value);
      push_req(func, row, col, value, $urandom_range(0, 63), $urandom_range(0, 1));
   endtask

   // Permutation entry. Before a final entry that completes a valid
   // permutation, every store entry the evaluation reads gets written.
   task automatic push_perm(input int loc, input bit last);
      int n;
      bit whole;
      int pi;
      int pj;
      if (last) begin
         n     = eff_nodes(cfg_nodes);
         whole = (gen_locs.size() + 1 == n) && (loc < n);
         foreach (gen_locs[k]) begin
            if (gen_locs[k] >= n) whole = 1'b0;
         end
         if (whole) begin
            gen_locs.push_back(loc);
            filling = 1'b1;
            for (int i = 0; i < n; i++) begin
               for (int j = 0; j < n; j++) begin
                  pi = gen_locs[i];
                  pj = gen_locs[j];
                  if (!flow_set[i*NODES_MAX+j]) push_matrix(FUNC_FLOW, i, j, rand_value());
                  if (!dist_set[pi*NODES_MAX+pj]) push_matrix(FUNC_DIST, pi, pj, rand_value());
               end
            end
            filling = 1'b0;
         end
         gen_locs.delete();
      end else begin
         gen_locs.push_back(loc);
      end
      push_req(FUNC_PERM, $urandom_range(0, 31), $urandom_range(0, 31),
               $urandom_range(0, 65535), loc, last);
   endtask

   // One random stretch of traffic; kind_sel below zero picks at random
   task automatic push_sequence(input int kind_sel);
      int n;
      int kind;
      int len;
      int bad_pos;
      int j;
      int tmp;
      bit shuffled;
      int order [0:NODES_MAX-1];
      n    = eff_nodes(cfg_nodes);
      kind = (kind_sel < 0) ? $urandom_range(0, 99) : kind_sel;
      if (kind < 30) begin
         // matrix writes, half of them inside the active square
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 1)) begin
               push_matrix($urandom_range(0, 1) ? FUNC_DIST : FUNC_FLOW,
                           $urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_value());
            end else begin
               push_matrix($urandom_range(0, 1) ? FUNC_DIST : FUNC_FLOW,
                           $urandom_range(0, 31), $urandom_range(0, 31), rand_value());
            end
         end
      end else if (kind < 75) begin
         // well-formed permutation, finishing any open one
         len = n - gen_locs.size();
         if (len < 1) len = 1;
         for (int k = 0; k < n; k++) order[k] = k;
         for (int k = n - 1; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
         end
         shuffled = $urandom_range(0, 1);
         for (int k = 0; k < len; k++) begin
            push_perm(shuffled ? order[k] : $urandom_range(0, n - 1), k == len - 1);
         end
      end else if (kind < 85) begin
         // short permutation
         len = (n > 1) ? $urandom_range(1, n - 1) : 1;
         for (int k = 0; k < len; k++) push_perm($urandom_range(0, n - 1), k == len - 1);
      end else if (kind < 92) begin
         // one location out of range
         bad_pos = $urandom_range(0, n - 1);
         for (int k = 0; k < n; k++) begin
            push_perm((k == bad_pos) ? $urandom_range(n, 63) : $urandom_range(0, n - 1),
                      k == n - 1);
         end
      end else if (kind < 97) begin
         // overlong, sometimes far enough to saturate the entry count
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 70) : n + $urandom_range(1, 4);
         for (int k = 0; k < len; k++) push_perm($urandom_range(0, n - 1), k == len - 1);
      end else begin
         // unused func code, must be ignored
         len = $urandom_range(1, 3);
         for (int k = 0; k < len; k++) begin
            push_req(FUNC_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 65535), $urandom_range(0, 63), $urandom_range(0, 1));
         end
      end
   endtask

   // Register write followed by a read-back of the same register
   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      logic [31:0] want;
      logic [31:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_idx == REG_NODE_COUNT) begin
         cfg_nodes = value[5:0];
         want      = {26'd0, value[5:0]};
      end else begin
         cfg_penalty = value;
         want        = value;
      end
      if (got !== want) note_fault("register read-back", want, got);
   endtask

   // Wait until every transaction is accepted and every result is back
   task automatic wait_drained(input int extra);
      while (req_pending_q.size() != 0 || req_tvalid || cost_expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (extra) @(posedge clock);
   endtask

   // Request driver
   always @(negedge clock) begin : req_driver
      req_item_t item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (req_tvalid && !req_taken) begin
         // transaction still on offer
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap    <= req_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         req_gap    <= $urandom_range(0, 15);
      end else if (req_pending_q.size() != 0) begin
         item = req_pending_q.pop_front();
         req_tdata  <= {item.location, item.value, item.col, item.row};
         req_tuser  <= item.func;
         req_tlast  <= item.last;
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response back-pressure, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_left      <= LONG_HOLD;
         rsp_tready     <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap    <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < rsp_gap_pct) begin
         rsp_gap    <= $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin : monitor
      cost_result_t want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) cost_step(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (cost_expected_q.size() == 0) begin
               note_fault("unexpected result", '0, {rsp_tuser, rsp_tdata});
            end else begin
               want = cost_expected_q.pop_front();
               if (rsp_tdata !== {6'd0, want.cost}) note_fault("cost", want.cost, rsp_tdata);
               if (rsp_tuser !== want.status) note_fault("status", want.status, rsp_tuser);
            end
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      int          phase;
      int          stop;
      int          nodes;
      logic [31:0] penalty;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset configuration, 32 nodes, zero penalty
      push_matrix(FUNC_FLOW, 31, 31, 65535);
      push_matrix(FUNC_DIST, 0, 0, 0);
      push_req(FUNC_NONE, 31, 31, 65535, 63, 1'b1);
      push_perm(0, 1'b1);
      push_perm(63, 1'b1);
      push_perm(3, 1'b0);
      push_perm(40, 1'b1);
      wait_drained(SETTLE);

      // Two nodes, largest penalty: short, full-scale complete, overlong, loc = n
      csr_write(REG_NODE_COUNT, 32'd2);
      csr_write(REG_MISSING_PENALTY, 32'hFFFF_FFFF);
      push_perm(1, 1'b1);
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            push_matrix(FUNC_FLOW, i, j, 65535);
            push_matrix(FUNC_DIST, i, j, 65535);
         end
      end
      push_perm(1, 1'b0);
      push_perm(0, 1'b1);
      push_perm(0, 1'b0);
      push_perm(1, 1'b0);
      push_perm(0, 1'b1);
      push_perm(2, 1'b0);
      push_perm(0, 1'b1);
      wait_drained(SETTLE);

      // Node count zero behaves as one
      csr_write(REG_NODE_COUNT, 32'd0);
      push_perm(0, 1'b1);
      push_perm(0, 1'b0);
      push_perm(0, 1'b1);
      wait_drained(SETTLE);

      // Node count lowered in the middle of a permutation
      csr_write(REG_NODE_COUNT, 32'd4);
      push_perm(3, 1'b0);
      push_perm(2, 1'b0);
      wait_drained(SETTLE);
      csr_write(REG_NODE_COUNT, 32'd3);
      push_perm(0, 1'b1);
      wait_drained(SETTLE);

      // Random phases, each with its own configuration and idling
      gen_count     = 0;
      long_hold_req = 1'b1;
      phase         = 0;
      while (gen_count < RANDOM_ITEMS) begin
         if (phase == 3) nodes = $urandom_range(33, 63);
         else if ($urandom_range(0, 9) == 0) nodes = $urandom_range(9, 16);
         else if ($urandom_range(0, 9) == 0) nodes = 0;
         else nodes = $urandom_range(1, 8);
         case ($urandom_range(0, 3))
            0: penalty = '0;
            1: penalty = 32'hFFFF_FFFF;
            default: penalty = $urandom;
         endcase
         csr_write(REG_NODE_COUNT, ($urandom & 32'hFFFF_FFC0) | nodes);
         csr_write(REG_MISSING_PENALTY, penalty);
         req_gap_pct = pick_gap();
         rsp_gap_pct = pick_gap();
         stop = gen_count + ((phase == 3) ? 80 : $urandom_range(30, 120));
         while (gen_count < stop) push_sequence(-1);
         // sometimes leave a permutation open across the next register write
         if ($urandom_range(0, 3) == 0) begin
            for (int k = $urandom_range(1, 3); k > 0; k--) begin
               push_perm($urandom_range(0, eff_nodes(cfg_nodes) - 1), 1'b0);
            end
         end
         wait_drained(SETTLE);
         phase++;
      end

      // Tail: full size, no idling
      quiet_tail = 1'b1;
      csr_write(REG_NODE_COUNT, 32'd32);
      csr_write(REG_MISSING_PENALTY, $urandom);
      push_sequence(50);
      stop = gen_count + 60;
      while (gen_count < stop) push_sequence(-1);
      wait_drained(TAIL_CYCLES);

      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### qap_cost_evaluator_core.f
+incdir+sv
sv/qap_pkg.sv
sv/qap_ram.sv
sv/qap_cost_evaluator_core.sv
tb/tb.sv
